### hw/rtl/prefix_code_table_decoder_top_defines.svh
// Assertion macros for the prefix code table decoder.
// Used by the top level; the including module must have clk and arst_n in scope.
`ifndef PREFIX_CODE_TABLE_DECODER_TOP_DEFINES_SVH
`define PREFIX_CODE_TABLE_DECODER_TOP_DEFINES_SVH

// A property that must hold at every clock edge outside of reset.
`define PCTD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An implication checked in the same cycle outside of reset.
`define PCTD_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### hw/rtl/pctd_pkg.sv
// Shared types and constants of the prefix code table decoder.
// No dependencies; used by the channel interfaces and the top level.
package pctd_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int MAX_CODE_LEN  = 32;
	localparam int SYM_W         = 21;
	localparam int BYTE_W        = 8;

	localparam int NODE_DEPTH  = TABLE_ENTRIES * MAX_CODE_LEN + 1;
	localparam int NODE_W      = $clog2(NODE_DEPTH);
	localparam int COUNT_W     = $clog2(TABLE_ENTRIES + 1);
	localparam int LEN_W       = $clog2(MAX_CODE_LEN + 1);
	localparam int IDX_W       = $clog2(MAX_CODE_LEN);
	localparam int BIT_CNT_W   = $clog2(BYTE_W);

	localparam logic [SYM_W-1:0] CH_START  = SYM_W'('h3B);
	localparam logic [SYM_W-1:0] CH_MIDDLE = SYM_W'('h2D);
	localparam logic [SYM_W-1:0] CH_END    = SYM_W'('h21);
	localparam logic [SYM_W-1:0] CH_ONE    = SYM_W'('h31);
	localparam logic [SYM_W-1:0] CH_ZERO   = SYM_W'('h30);

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_TABLE_FULL,
		ERR_CODE_LONG,
		ERR_DECODE_OVF
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR_EXEC,
		ST_HDR_NEW,
		ST_HDR_LINK,
		ST_DEC_REWALK,
		ST_DEC_BIT,
		ST_FLUSH
	} state_t;

	typedef logic [NODE_W-1:0] node_ptr_t;

	// One child slot of a trie node: where the child lives and the symbol it ends.
	typedef struct packed {
		node_ptr_t        ptr;
		logic             symv;
		logic [SYM_W-1:0] sym;
	} child_t;

endpackage

### hw/rtl/pctd_ifs.sv
// Request and result channel interfaces of the prefix code table decoder.
// Depends on pctd_pkg for the field widths.
interface pctd_item_if;
	logic                           valid;
	logic                           ready;
	logic                           operation;
	logic [pctd_pkg::SYM_W-1:0]     header_char;
	logic [pctd_pkg::BYTE_W-1:0]    data_byte;

	modport source (output valid, operation, header_char, data_byte, input ready);
	modport sink (input valid, operation, header_char, data_byte, output ready);
endinterface

interface pctd_result_if;
	logic                           valid;
	logic                           ready;
	logic [pctd_pkg::SYM_W-1:0]     symbol;
	logic [1:0]                     error_code;
	logic                           last;

	modport source (output valid, symbol, error_code, last, input ready);
	modport sink (input valid, symbol, error_code, last, output ready);
endinterface

### hw/rtl/prefix_code_table_decoder_top.sv
// Prefix code table decoder: header parser, trie node memory and bit-serial decoder.
// Depends on pctd_pkg, pctd_ifs.sv and prefix_code_table_decoder_top_defines.svh.
//
//   channel  | role | payload
//   ---------+------+-------------------------------------------
//   item     | sink | operation, header_char, data_byte
//   result   | src  | symbol, error_code, last
//
// A data byte is accepted, walked one code bit per cycle through the single read port
// of the node memory, and ends with a flush of the held result.
// When the code in progress has left the trie and the header has grown since,
// a byte first re-walks the stored code bits. A header character is accepted, executed
// and flushed, with a new-node and a link step between when it adds a trie node.
// Reset clears all control state; the node memory needs no clearing since
// nodes are allocated by a fill count. A full result register stalls the bit walk.
`include "prefix_code_table_decoder_top_defines.svh"

module prefix_code_table_decoder_top (
	input  logic                  clk,
	input  logic                  arst_n,
	pctd_item_if.sink             item,
	pctd_result_if.source         result
);

	localparam int MAX_LEN = pctd_pkg::MAX_CODE_LEN;

	pctd_pkg::state_t state_q, state_d;

	logic [pctd_pkg::SYM_W-1:0]     hchar_q, hchar_d;
	logic [pctd_pkg::BYTE_W-1:0]    sh_q, sh_d;
	logic [pctd_pkg::BIT_CNT_W-1:0] bcnt_q, bcnt_d;

	logic fl_letter_q, fl_letter_d;
	logic fl_code_q, fl_code_d;
	logic fl_closed_q, fl_closed_d;
	logic fl_done_q, fl_done_d;

	logic [pctd_pkg::SYM_W-1:0]     psym_q, psym_d;
	pctd_pkg::node_ptr_t            pend_q, pend_d;
	pctd_pkg::node_ptr_t            pend_par_q, pend_par_d;
	logic                           pend_bit_q, pend_bit_d;
	logic [pctd_pkg::LEN_W-1:0]     pend_len_q, pend_len_d;
	logic                           pend_off_q, pend_off_d;
	logic [pctd_pkg::COUNT_W-1:0]   ent_cnt_q, ent_cnt_d;
	pctd_pkg::node_ptr_t            node_cnt_q, node_cnt_d;

	logic [MAX_LEN-1:0]             dec_code_q, dec_code_d;
	logic [pctd_pkg::LEN_W-1:0]     dec_len_q, dec_len_d;
	pctd_pkg::node_ptr_t            dec_cur_q, dec_cur_d;
	logic                           dec_off_q, dec_off_d;
	logic                           grew_q, grew_d;
	logic [pctd_pkg::IDX_W-1:0]     rw_idx_q, rw_idx_d;

	pctd_pkg::child_t root0_q, root0_d, root1_q, root1_d;
	pctd_pkg::child_t rd0_q, rd1_q;

	logic                           hv_q, hv_d;
	logic [pctd_pkg::SYM_W-1:0]     hsym_q, hsym_d;
	pctd_pkg::err_t                 herr_q, herr_d;

	logic                           ov_q, ov_d;
	logic [pctd_pkg::SYM_W-1:0]     osym_q, osym_d;
	pctd_pkg::err_t                 oerr_q, oerr_d;
	logic                           olast_q, olast_d;

	pctd_pkg::child_t c0_mem [pctd_pkg::NODE_DEPTH];
	pctd_pkg::child_t c1_mem [pctd_pkg::NODE_DEPTH];

	logic                rd_en, wr0_en, wr1_en;
	pctd_pkg::node_ptr_t rd_addr, wr0_addr, wr1_addr;
	pctd_pkg::child_t    wr0_data, wr1_data;

	logic in_ready;
	logic accept, out_free;
	pctd_pkg::node_ptr_t walk_node;
	pctd_pkg::child_t view0, view1, hdr_ent, dent, rent;
	logic hc_one, hc_bit, hc_end, hc_start, hc_mid;
	logic tbl_full, code_long, hdr_new;
	logic dbit, dhit, dovf, dprod, dstall, dlast_bit, rbit;
	logic [pctd_pkg::LEN_W-1:0] dlen_n, len_m1;

	assign accept   = item.valid && in_ready;
	assign out_free = !ov_q || result.ready;

	assign walk_node = (state_q == pctd_pkg::ST_DEC_BIT || state_q == pctd_pkg::ST_DEC_REWALK)
		? dec_cur_q : pend_q;
	assign view0 = (walk_node == '0) ? root0_q : rd0_q;
	assign view1 = (walk_node == '0) ? root1_q : rd1_q;

	assign hc_one   = hchar_q == pctd_pkg::CH_ONE;
	assign hc_bit   = hc_one || hchar_q == pctd_pkg::CH_ZERO;
	assign hc_end   = hchar_q == pctd_pkg::CH_END;
	assign hc_start = hchar_q == pctd_pkg::CH_START;
	assign hc_mid   = hchar_q == pctd_pkg::CH_MIDDLE;

	assign tbl_full  = ent_cnt_q == pctd_pkg::COUNT_W'(pctd_pkg::TABLE_ENTRIES);
	assign code_long = pend_len_q == pctd_pkg::LEN_W'(MAX_LEN);
	assign hdr_ent   = hc_one ? view1 : view0;
	assign hdr_new   = !fl_done_q && !fl_letter_q && !hc_end && fl_code_q && hc_bit
		&& !code_long && !tbl_full && !pend_off_q && hdr_ent.ptr == '0;

	assign dbit      = sh_q[pctd_pkg::BYTE_W-1];
	assign dent      = dbit ? view1 : view0;
	assign dlen_n    = dec_len_q + pctd_pkg::LEN_W'(1);
	assign dhit      = !dec_off_q && dent.symv && dent.ptr != '0;
	assign dovf      = !dhit && dlen_n == pctd_pkg::LEN_W'(MAX_LEN);
	assign dprod     = dhit || dovf;
	assign dstall    = dprod && hv_q && !out_free;
	assign dlast_bit = bcnt_q == pctd_pkg::BIT_CNT_W'(pctd_pkg::BYTE_W - 1);
	assign len_m1    = dec_len_q - pctd_pkg::LEN_W'(1);

	assign rbit = dec_code_q[rw_idx_q];
	assign rent = rbit ? view1 : view0;

	assign item.ready        = in_ready;
	assign result.valid      = ov_q;
	assign result.symbol     = osym_q;
	assign result.error_code = oerr_q;
	assign result.last       = olast_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pctd_pkg::ST_IDLE: begin
				if (accept) begin
					if (!item.operation) begin
						state_d = pctd_pkg::ST_HDR_EXEC;
					end else if (dec_off_q && grew_q) begin
						state_d = pctd_pkg::ST_DEC_REWALK;
					end else begin
						state_d = pctd_pkg::ST_DEC_BIT;
					end
				end
			end
			pctd_pkg::ST_HDR_EXEC: begin
				state_d = hdr_new ? pctd_pkg::ST_HDR_NEW : pctd_pkg::ST_FLUSH;
			end
			pctd_pkg::ST_HDR_NEW: begin
				state_d = pctd_pkg::ST_HDR_LINK;
			end
			pctd_pkg::ST_HDR_LINK: begin
				state_d = pctd_pkg::ST_FLUSH;
			end
			pctd_pkg::ST_DEC_REWALK: begin
				if (rent.ptr == '0 || rw_idx_q == '0) begin
					state_d = pctd_pkg::ST_DEC_BIT;
				end
			end
			pctd_pkg::ST_DEC_BIT: begin
				if (!dstall && dlast_bit) begin
					state_d = pctd_pkg::ST_FLUSH;
				end
			end
			pctd_pkg::ST_FLUSH: begin
				if (!hv_q || out_free) begin
					state_d = pctd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pctd_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		logic                       push;
		logic [pctd_pkg::SYM_W-1:0] push_sym;
		pctd_pkg::err_t             push_err;
		logic                       push_last;

		push      = 1'b0;
		push_sym  = hsym_q;
		push_err  = herr_q;
		push_last = 1'b0;

		in_ready = state_q == pctd_pkg::ST_IDLE;

		hchar_d     = hchar_q;
		sh_d        = sh_q;
		bcnt_d      = bcnt_q;
		fl_letter_d = fl_letter_q;
		fl_code_d   = fl_code_q;
		fl_closed_d = fl_closed_q;
		fl_done_d   = fl_done_q;
		psym_d      = psym_q;
		pend_d      = pend_q;
		pend_par_d  = pend_par_q;
		pend_bit_d  = pend_bit_q;
		pend_len_d  = pend_len_q;
		pend_off_d  = pend_off_q;
		ent_cnt_d   = ent_cnt_q;
		node_cnt_d  = node_cnt_q;
		dec_code_d  = dec_code_q;
		dec_len_d   = dec_len_q;
		dec_cur_d   = dec_cur_q;
		dec_off_d   = dec_off_q;
		grew_d      = grew_q;
		rw_idx_d    = rw_idx_q;
		root0_d     = root0_q;
		root1_d     = root1_q;
		hv_d        = hv_q;
		hsym_d      = hsym_q;
		herr_d      = herr_q;

		rd_en    = 1'b0;
		rd_addr  = pend_q;
		wr0_en   = 1'b0;
		wr1_en   = 1'b0;
		wr0_addr = pend_par_q;
		wr1_addr = pend_par_q;
		wr0_data = '0;
		wr1_data = '0;

		case (state_q)
			pctd_pkg::ST_IDLE: begin
				if (accept) begin
					hchar_d = item.header_char;
					sh_d    = item.data_byte;
					bcnt_d  = '0;
					rd_en   = 1'b1;
					rd_addr = item.operation ? dec_cur_q : pend_q;
					if (item.operation) begin
						grew_d = 1'b0;
						if (dec_off_q && grew_q) begin
							dec_cur_d = '0;
							rw_idx_d  = len_m1[pctd_pkg::IDX_W-1:0];
						end
					end
				end
			end
			pctd_pkg::ST_HDR_EXEC: begin
				if (!fl_done_q) begin
					if (fl_letter_q) begin
						psym_d      = hchar_q;
						fl_letter_d = 1'b0;
					end else if (hc_end) begin
						if (fl_closed_q) begin
							fl_done_d = 1'b1;
						end else begin
							fl_code_d = 1'b0;
							if (!tbl_full) begin
								ent_cnt_d = ent_cnt_q + pctd_pkg::COUNT_W'(1);
								// A zero-length code lives at the root and can never match.
								if (pend_q != '0) begin
									if (pend_par_q == '0) begin
										if (pend_bit_q) begin
											root1_d = '{ptr: pend_q, symv: 1'b1, sym: psym_q};
										end else begin
											root0_d = '{ptr: pend_q, symv: 1'b1, sym: psym_q};
										end
									end else if (pend_bit_q) begin
										wr1_en   = 1'b1;
										wr1_data = '{ptr: pend_q, symv: 1'b1, sym: psym_q};
									end else begin
										wr0_en   = 1'b1;
										wr0_data = '{ptr: pend_q, symv: 1'b1, sym: psym_q};
									end
								end
							end else begin
								hv_d   = 1'b1;
								hsym_d = '0;
								herr_d = pctd_pkg::ERR_TABLE_FULL;
							end
							pend_d      = '0;
							pend_len_d  = '0;
							pend_off_d  = 1'b0;
							fl_closed_d = 1'b1;
						end
					end else if (fl_code_q) begin
						if (hc_bit) begin
							if (code_long) begin
								hv_d   = 1'b1;
								hsym_d = '0;
								herr_d = pctd_pkg::ERR_CODE_LONG;
							end else begin
								pend_len_d = pend_len_q + pctd_pkg::LEN_W'(1);
								if (tbl_full) begin
									pend_off_d = 1'b1;
								end else if (!pend_off_q && hdr_ent.ptr != '0) begin
									pend_par_d = pend_q;
									pend_bit_d = hc_one;
									pend_d     = hdr_ent.ptr;
								end
							end
						end
					end else if (hc_start) begin
						fl_letter_d = 1'b1;
						fl_closed_d = 1'b0;
					end else if (hc_mid) begin
						fl_letter_d = 1'b0;
						fl_code_d   = 1'b1;
					end
				end
			end
			pctd_pkg::ST_HDR_NEW: begin
				wr0_en   = 1'b1;
				wr1_en   = 1'b1;
				wr0_addr = node_cnt_q;
				wr1_addr = node_cnt_q;
			end
			pctd_pkg::ST_HDR_LINK: begin
				if (pend_q == '0) begin
					if (hc_one) begin
						root1_d = '{ptr: node_cnt_q, symv: 1'b0, sym: '0};
					end else begin
						root0_d = '{ptr: node_cnt_q, symv: 1'b0, sym: '0};
					end
				end else if (hc_one) begin
					wr1_en   = 1'b1;
					wr1_addr = pend_q;
					wr1_data = '{ptr: node_cnt_q, symv: 1'b0, sym: '0};
				end else begin
					wr0_en   = 1'b1;
					wr0_addr = pend_q;
					wr0_data = '{ptr: node_cnt_q, symv: 1'b0, sym: '0};
				end
				pend_par_d = pend_q;
				pend_bit_d = hc_one;
				pend_d     = node_cnt_q;
				node_cnt_d = node_cnt_q + pctd_pkg::NODE_W'(1);
				grew_d     = 1'b1;
			end
			pctd_pkg::ST_DEC_REWALK: begin
				if (rent.ptr == '0) begin
					dec_cur_d = '0;
				end else begin
					dec_cur_d = rent.ptr;
					rd_en     = 1'b1;
					rd_addr   = rent.ptr;
					rw_idx_d  = rw_idx_q - pctd_pkg::IDX_W'(1);
					if (rw_idx_q == '0) begin
						dec_off_d = 1'b0;
					end
				end
			end
			pctd_pkg::ST_DEC_BIT: begin
				if (!dstall) begin
					sh_d   = {sh_q[pctd_pkg::BYTE_W-2:0], 1'b0};
					bcnt_d = bcnt_q + pctd_pkg::BIT_CNT_W'(1);
					if (dprod) begin
						push     = hv_q;
						hv_d     = 1'b1;
						hsym_d   = dhit ? dent.sym : '0;
						herr_d   = dhit ? pctd_pkg::ERR_NONE : pctd_pkg::ERR_DECODE_OVF;
						dec_len_d  = '0;
						dec_code_d = '0;
						dec_cur_d  = '0;
						dec_off_d  = 1'b0;
					end else begin
						dec_len_d  = dlen_n;
						dec_code_d = {dec_code_q[MAX_LEN-2:0], dbit};
						if (!dec_off_q) begin
							if (dent.ptr == '0) begin
								dec_off_d = 1'b1;
								dec_cur_d = '0;
							end else begin
								dec_cur_d = dent.ptr;
								rd_en     = 1'b1;
								rd_addr   = dent.ptr;
							end
						end
					end
				end
			end
			pctd_pkg::ST_FLUSH: begin
				if (hv_q && out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					hv_d      = 1'b0;
				end
			end
			default: begin
			end
		endcase

		ov_d    = ov_q;
		osym_d  = osym_q;
		oerr_d  = oerr_q;
		olast_d = olast_q;
		if (push) begin
			ov_d    = 1'b1;
			osym_d  = push_sym;
			oerr_d  = push_err;
			olast_d = push_last;
		end else if (result.ready) begin
			ov_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pctd_pkg::ST_IDLE;
			bcnt_q      <= '0;
			fl_letter_q <= 1'b0;
			fl_code_q   <= 1'b0;
			fl_closed_q <= 1'b0;
			fl_done_q   <= 1'b0;
			psym_q      <= '0;
			pend_q      <= '0;
			pend_par_q  <= '0;
			pend_bit_q  <= 1'b0;
			pend_len_q  <= '0;
			pend_off_q  <= 1'b0;
			ent_cnt_q   <= '0;
			node_cnt_q  <= pctd_pkg::NODE_W'(1);
			dec_len_q   <= '0;
			dec_cur_q   <= '0;
			dec_off_q   <= 1'b0;
			grew_q      <= 1'b0;
			rw_idx_q    <= '0;
			root0_q     <= '0;
			root1_q     <= '0;
			hv_q        <= 1'b0;
			ov_q        <= 1'b0;
		end else begin
			state_q     <= state_d;
			bcnt_q      <= bcnt_d;
			fl_letter_q <= fl_letter_d;
			fl_code_q   <= fl_code_d;
			fl_closed_q <= fl_closed_d;
			fl_done_q   <= fl_done_d;
			psym_q      <= psym_d;
			pend_q      <= pend_d;
			pend_par_q  <= pend_par_d;
			pend_bit_q  <= pend_bit_d;
			pend_len_q  <= pend_len_d;
			pend_off_q  <= pend_off_d;
			ent_cnt_q   <= ent_cnt_d;
			node_cnt_q  <= node_cnt_d;
			dec_len_q   <= dec_len_d;
			dec_cur_q   <= dec_cur_d;
			dec_off_q   <= dec_off_d;
			grew_q      <= grew_d;
			rw_idx_q    <= rw_idx_d;
			root0_q     <= root0_d;
			root1_q     <= root1_d;
			hv_q        <= hv_d;
			ov_q        <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		hchar_q    <= hchar_d;
		sh_q       <= sh_d;
		dec_code_q <= dec_code_d;
		hsym_q     <= hsym_d;
		herr_q     <= herr_d;
		osym_q     <= osym_d;
		oerr_q     <= oerr_d;
		olast_q    <= olast_d;
	end

	always_ff @(posedge clk) begin
		if (wr0_en) begin
			c0_mem[wr0_addr] <= wr0_data;
		end
		if (wr1_en) begin
			c1_mem[wr1_addr] <= wr1_data;
		end
		if (rd_en) begin
			rd0_q <= c0_mem[rd_addr];
			rd1_q <= c1_mem[rd_addr];
		end
	end

	`PCTD_ASSERT(a_idle_held_empty, !in_ready || !hv_q, "held result left over at idle")
	`PCTD_ASSERT_IMPLY(a_node_room, state_q == pctd_pkg::ST_HDR_NEW, node_cnt_q < pctd_pkg::NODE_W'(pctd_pkg::NODE_DEPTH), "trie node memory overrun")
	`PCTD_ASSERT(a_dec_len_range, dec_len_q < pctd_pkg::LEN_W'(MAX_LEN), "decode length not cleared at limit")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the prefix code table decoder: header grammar, table limits,
// bit-serial decoding and stalls on both channels, checked against an in-bench table model.
// Depends on pctd_pkg, pctd_ifs.sv and prefix_code_table_decoder_top.
module tb;
	import pctd_pkg::*;

	typedef struct {
		logic [SYM_W-1:0] symbol;
		err_t             error_code;
		logic             last;
	} decoded_t;

	logic clk = 1'b0;
	logic arst_n;

	always #5 clk = ~clk;

	pctd_item_if   item_ch ();
	pctd_result_if result_ch ();

	prefix_code_table_decoder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	decoded_t symbols_due[$];
	int       mismatches;
	int       requests_sent;
	int       burst_left;
	int       hold_request;
	int       hold_left;
	int       stall_mode;
	int       pattern_left;

	bit [MAX_CODE_LEN-1:0] tbl_code [TABLE_ENTRIES];
	int                    tbl_len [TABLE_ENTRIES];
	bit [SYM_W-1:0]        tbl_sym [TABLE_ENTRIES];
	int                    tbl_count;
	bit                    hdr_letter, hdr_in_code, hdr_closed, hdr_done;
	bit [SYM_W-1:0]        pend_sym;
	bit [MAX_CODE_LEN-1:0] pend_code;
	int                    pend_len;
	bit [MAX_CODE_LEN-1:0] dec_code;
	int                    dec_len;

	function automatic void queue_result(bit [SYM_W-1:0] sym, err_t err);
		decoded_t d;
		d.symbol     = sym;
		d.error_code = err;
		d.last       = 1'b0;
		symbols_due.push_back(d);
	endfunction

	function automatic int table_header_char(bit [SYM_W-1:0] c);
		int n;
		n = 0;
		if (hdr_done)
			return 0;
		if (hdr_letter) begin
			pend_sym   = c;
			hdr_letter = 1'b0;
		end else if (c == CH_END) begin
			if (hdr_closed) begin
				hdr_done = 1'b1;
			end else begin
				hdr_in_code = 1'b0;
				if (tbl_count < TABLE_ENTRIES) begin
					tbl_code[tbl_count] = pend_code;
					tbl_len[tbl_count]  = pend_len;
					tbl_sym[tbl_count]  = pend_sym;
					tbl_count++;
				end else begin
					queue_result('0, ERR_TABLE_FULL);
					n = 1;
				end
				pend_code  = '0;
				pend_len   = 0;
				hdr_closed = 1'b1;
			end
		end else if (hdr_in_code) begin
			if (c == CH_ZERO || c == CH_ONE) begin
				if (pend_len >= MAX_CODE_LEN) begin
					queue_result('0, ERR_CODE_LONG);
					n = 1;
				end else begin
					pend_code = {pend_code[MAX_CODE_LEN-2:0], (c == CH_ONE)};
					pend_len++;
				end
			end
		end else if (c == CH_START) begin
			hdr_letter = 1'b1;
			hdr_closed = 1'b0;
		end else if (c == CH_MIDDLE) begin
			hdr_letter  = 1'b0;
			hdr_in_code = 1'b1;
		end
		return n;
	endfunction

	function automatic int table_decode_byte(bit [7:0] dv);
		int             n;
		bit             hit;
		bit [SYM_W-1:0] sym;
		n = 0;
		for (int b = 7; b >= 0; b--) begin
			hit      = 1'b0;
			sym      = '0;
			dec_code = {dec_code[MAX_CODE_LEN-2:0], dv[b]};
			dec_len++;
			for (int i = 0; i < tbl_count; i++) begin
				if (tbl_len[i] == dec_len && tbl_code[i] == dec_code) begin
					hit = 1'b1;
					sym = tbl_sym[i];
				end
			end
			if (hit) begin
				queue_result(sym, ERR_NONE);
				n++;
				dec_code = '0;
				dec_len  = 0;
			end else if (dec_len >= MAX_CODE_LEN) begin
				queue_result('0, ERR_DECODE_OVF);
				n++;
				dec_code = '0;
				dec_len  = 0;
			end
		end
		return n;
	endfunction

	function automatic void predict_request(bit op, bit [SYM_W-1:0] ch, bit [7:0] dv);
		int n;
		if (op)
			n = table_decode_byte(dv);
		else
			n = table_header_char(ch);
		if (n > 0)
			symbols_due[symbols_due.size() - 1].last = 1'b1;
	endfunction

	function automatic bit [SYM_W-1:0] noise_char();
		case ($urandom_range(0, 5))
			0: return CH_START;
			1: return CH_MIDDLE;
			2: return CH_END;
			3: return SYM_W'($urandom_range(32, 126));
			default: return SYM_W'($urandom);
		endcase
	endfunction

	function automatic bit [SYM_W-1:0] rand_letter();
		if ($urandom_range(0, 1))
			return SYM_W'($urandom);
		return SYM_W'($urandom_range(32, 126));
	endfunction

	task automatic send_request(input bit op, input bit [SYM_W-1:0] ch, input bit [7:0] dv);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_ch.valid       <= 1'b1;
		item_ch.operation   <= op;
		item_ch.header_char <= ch;
		item_ch.data_byte   <= dv;
		do @(posedge clk); while (!item_ch.ready);
		predict_request(op, ch, dv);
		requests_sent++;
	endtask

	task automatic send_header(input bit [SYM_W-1:0] c);
		send_request(1'b0, c, 8'($urandom));
	endtask

	task automatic send_data(input bit [7:0] b);
		send_request(1'b1, SYM_W'($urandom), b);
	endtask

	// A '!' right after a closed entry would end the header early, and a '-' would open a code
	// with no new letter, so either becomes a ';' while the table is still being built.
	task automatic send_guarded(input bit [SYM_W-1:0] c);
		if (!hdr_done && hdr_closed && !hdr_letter && (c == CH_END || c == CH_MIDDLE))
			c = CH_START;
		send_header(c);
	endtask

	task automatic send_entry(input bit [SYM_W-1:0] letter, input bit [39:0] code,
			input int len, input bit noisy);
		send_guarded(CH_START);
		send_guarded(letter);
		send_guarded(CH_MIDDLE);
		for (int i = len - 1; i >= 0; i--) begin
			if (noisy && $urandom_range(0, 3) == 0)
				send_guarded(noise_char());
			send_guarded(code[i] ? CH_ONE : CH_ZERO);
		end
		send_guarded(CH_END);
	endtask

	task automatic test_empty_table();
		send_data(8'h00);
		send_data(8'hFF);
		send_data(8'hA5);
		send_data(8'h5A);
	endtask

	task automatic test_header_grammar();
		send_header(21'h3F);
		send_header(21'h1FFFFF);
		send_header(CH_END);
		send_header(CH_START);
		send_header(21'h1FFFFF);
		send_header(CH_MIDDLE);
		send_header(CH_ONE);
		send_header(21'h32);
		send_header(CH_START);
		send_header(CH_ZERO);
		send_header(CH_END);
		send_entry(21'h0, 40'b0110, 4, 1'b0);
		send_entry(CH_END, 40'b11, 2, 1'b0);
		send_entry(21'h64, 40'b10, 2, 1'b0);
		send_data(8'hB6);
		send_data(8'hFF);
		send_data(8'h66);
	endtask

	task automatic test_long_code();
		send_entry(21'h7A, {7'd0, 32'h00FF_F00D, 1'b1}, 33, 1'b0);
		for (int tries = 0; tries < 8 && dec_len != 0; tries++)
			send_data(8'($urandom));
		send_data(8'h00);
		send_data(8'hFF);
		send_data(8'hF0);
		send_data(8'h0D);
	endtask

	task automatic test_random_traffic();
		int start;
		bit pressure_sent;
		int len;
		start         = requests_sent;
		pressure_sent = 1'b0;
		while (requests_sent - start < 210) begin
			if (!pressure_sent && requests_sent - start >= 70) begin
				hold_request  = 300;
				pressure_sent = 1'b1;
				repeat (12) send_data(8'($urandom));
			end
			len = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 34) : $urandom_range(2, 8);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7:
					send_entry(rand_letter(), {$urandom, $urandom}, len, $urandom_range(0, 3) == 0);
				8, 9, 10, 11, 12, 13, 14, 15:
					repeat ($urandom_range(1, 4)) send_data(8'($urandom));
				16, 17: send_guarded(noise_char());
				18: begin
					send_guarded(CH_START);
					send_guarded(rand_letter());
					send_guarded(CH_END);
				end
				default: begin
					send_guarded(CH_START);
					send_guarded(rand_letter());
					send_guarded(CH_MIDDLE);
					repeat ($urandom_range(1, 5))
						send_guarded($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
				end
			endcase
		end
	endtask

	task automatic test_table_full();
		if (hdr_in_code)
			send_header(CH_END);
		while (tbl_count < TABLE_ENTRIES - 2)
			send_entry(rand_letter(), 40'($urandom), $urandom_range(0, 3), 1'b0);
		send_entry(21'h30, 40'b0, 1, 1'b0);
		send_entry(21'h31, 40'b1, 1, 1'b0);
		send_entry(21'h71, 40'b101, 3, 1'b0);
		send_header(CH_END);
	endtask

	task automatic test_after_header_done();
		send_header(CH_START);
		send_header(21'h61);
		send_header(CH_MIDDLE);
		send_header(CH_ZERO);
		send_header(CH_END);
		send_header(CH_END);
		send_header(21'h1FFFFF);
		send_data(8'h00);
		send_data(8'hFF);
		send_data(8'h5A);
		repeat (3) send_data(8'($urandom));
	endtask

	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					stall_mode   = $urandom_range(0, 3);
					pattern_left = $urandom_range(20, 120);
				end
				pattern_left--;
				case (stall_mode)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= 1'($urandom_range(0, 1));
					2: result_ch.ready <= ($urandom_range(0, 3) == 0);
					default: result_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_result
		decoded_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (symbols_due.size() == 0) begin
				$error("result with nothing expected: symbol %h, error_code %0d",
					result_ch.symbol, result_ch.error_code);
				mismatches++;
			end else begin
				want = symbols_due.pop_front();
				if (result_ch.symbol !== want.symbol) begin
					$error("symbol: expected %h, got %h", want.symbol, result_ch.symbol);
					mismatches++;
				end
				if (result_ch.error_code !== want.error_code) begin
					$error("error_code: expected %0d, got %0d", want.error_code,
						result_ch.error_code);
					mismatches++;
				end
				if (result_ch.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result_ch.last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#(5_000_000);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		arst_n              <= 1'b0;
		item_ch.valid       <= 1'b0;
		item_ch.operation   <= 1'b0;
		item_ch.header_char <= '0;
		item_ch.data_byte   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_header_grammar();
		test_long_code();
		test_random_traffic();
		test_table_full();
		test_after_header_done();
		item_ch.valid <= 1'b0;
		while (symbols_due.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && symbols_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### prefix_code_table_decoder_top.f
+incdir+hw/rtl
hw/rtl/pctd_pkg.sv
hw/rtl/pctd_ifs.sv
hw/rtl/prefix_code_table_decoder_top.sv
tb/tb.sv
